@@ design/psnn_pkg.sv @@
// Shared types and constants for the point store with nearest-neighbor search.
// Used by point_store_nearest_neighbour; depends on nothing.
`default_nettype none

package psnn_pkg;

    localparam int COORD_W      = 16;
    localparam int CNT_W        = 7;
    localparam int CAPACITY_DEF = 64;

    typedef enum logic [1:0] {
        OP_INSERT  = 2'd0,
        OP_DELETE  = 2'd1,
        OP_FIND    = 2'd2,
        OP_NEAREST = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_EMPTY     = 2'd3
    } t_status;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } t_point;

    typedef struct packed {
        t_opcode                   opcode;
        logic signed [COORD_W-1:0] x_coord;
        logic signed [COORD_W-1:0] y_coord;
        logic signed [COORD_W-1:0] z_coord;
    } t_in_word;

    typedef struct packed {
        t_status                   status;
        logic                      found;
        logic signed [COORD_W-1:0] near_x;
        logic signed [COORD_W-1:0] near_y;
        logic signed [COORD_W-1:0] near_z;
        logic [CNT_W-1:0]          point_count;
    } t_out_word;

endpackage

`default_nettype wire

@@ design/point_store_nearest_neighbour.sv @@
// Point store with exact-match lookup, ordered delete and nearest-neighbor search.
// Top level; depends on psnn_pkg.
`default_nettype none

// Holds up to CAPACITY points in one table memory (one write port, one
// registered read port) and answers one word at a time. Insert, and a nearest
// search of an empty store, go from acceptance straight to the finish state.
// Find and delete scan the table one entry per cycle from the start and stop
// at the first match; a delete then moves every later entry down by one, one
// per cycle. Nearest scans every entry. The single read port of the table
// sets these scan rates. The result sits in an output register, so the next
// word is taken while a result still waits.
module point_store_nearest_neighbour #(
    parameter int CAPACITY = psnn_pkg::CAPACITY_DEF
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    input  psnn_pkg::t_in_word   i_in_data,
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    output psnn_pkg::t_out_word  o_out_data
);

    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int AW    = $clog2(CAPACITY);
    localparam int CB    = psnn_pkg::COORD_W;
    localparam int SQ_W  = 2 * CB;
    localparam int SUM_W = SQ_W + 2;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_SHIFT = 4'b0100,
        S_FIN   = 4'b1000
    } t_state;

    psnn_pkg::t_point    mem [CAPACITY];

    t_state              r_state, n_state;
    psnn_pkg::t_opcode   r_op;
    psnn_pkg::t_point    r_query;
    logic [CW-1:0]       r_count;
    logic [CW-1:0]       r_rd_idx;
    logic                r_a_valid;
    logic [CW-1:0]       r_a_idx;
    psnn_pkg::t_point    r_rd_data;
    logic                r_b_valid;
    psnn_pkg::t_point    r_b_pt;
    logic [SQ_W-1:0]     r_sq [3];
    logic                r_have_best;
    logic [SUM_W-1:0]    r_best;
    psnn_pkg::t_point    r_near;
    psnn_pkg::t_status   r_status;
    logic                r_found;
    logic                r_out_valid;
    psnn_pkg::t_out_word r_out;

    logic                in_acc;
    logic                issue;
    logic                match;
    logic                table_full;
    logic                scan_done;
    logic                shift_done;
    logic                we;
    logic [AW-1:0]       waddr;
    psnn_pkg::t_point    wdata;
    logic [CW-1:0]       dst_idx;
    logic signed [CB:0]  dx, dy, dz;
    logic [CB-1:0]       mx, my, mz;
    logic [SUM_W-1:0]    sum;
    logic                better;
    psnn_pkg::t_point    in_pt;

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign in_pt.x = i_in_data.x_coord;
    assign in_pt.y = i_in_data.y_coord;
    assign in_pt.z = i_in_data.z_coord;

    assign table_full = (r_count >= CW'(CAPACITY));
    assign issue = ((r_state == S_SCAN) || (r_state == S_SHIFT)) && (r_rd_idx < r_count);
    assign match = r_a_valid && (r_rd_data == r_query);
    assign scan_done  = (r_rd_idx >= r_count) && !r_a_valid && !r_b_valid;
    assign shift_done = (r_rd_idx >= r_count) && !r_a_valid;

    // table write: append on insert, move down by one during a delete
    assign dst_idx = r_a_idx - CW'(1);
    always_comb begin
        we    = 1'b0;
        waddr = r_count[AW-1:0];
        wdata = in_pt;
        if (in_acc && (i_in_data.opcode == psnn_pkg::OP_INSERT) && !table_full) begin
            we = 1'b1;
        end else if ((r_state == S_SHIFT) && r_a_valid) begin
            we    = 1'b1;
            waddr = dst_idx[AW-1:0];
            wdata = r_rd_data;
        end
    end

    // distance: abs differences, squared into registers, summed next cycle
    assign dx = (CB+1)'(r_rd_data.x) - (CB+1)'(r_query.x);
    assign dy = (CB+1)'(r_rd_data.y) - (CB+1)'(r_query.y);
    assign dz = (CB+1)'(r_rd_data.z) - (CB+1)'(r_query.z);
    assign mx = CB'(dx[CB] ? -dx : dx);
    assign my = CB'(dy[CB] ? -dy : dy);
    assign mz = CB'(dz[CB] ? -dz : dz);
    assign sum = SUM_W'(r_sq[0]) + SUM_W'(r_sq[1]) + SUM_W'(r_sq[2]);
    assign better = r_b_valid && (!r_have_best || (sum < r_best));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if ((i_in_data.opcode == psnn_pkg::OP_INSERT) ||
                        ((i_in_data.opcode == psnn_pkg::OP_NEAREST) && (r_count == '0))) begin
                        n_state = S_FIN;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if ((r_op != psnn_pkg::OP_NEAREST) && match) begin
                    n_state = (r_op == psnn_pkg::OP_DELETE) ? S_SHIFT : S_FIN;
                end else if (scan_done) begin
                    n_state = S_FIN;
                end
            end
            S_SHIFT: begin
                if (shift_done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        r_rd_data <= mem[r_rd_idx[AW-1:0]];
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_a_idx <= r_rd_idx;
        r_b_pt  <= r_rd_data;
        r_sq[0] <= SQ_W'(mx) * SQ_W'(mx);
        r_sq[1] <= SQ_W'(my) * SQ_W'(my);
        r_sq[2] <= SQ_W'(mz) * SQ_W'(mz);
        if (issue) begin
            r_rd_idx <= r_rd_idx + CW'(1);
        end
        if (in_acc) begin
            r_op        <= i_in_data.opcode;
            r_query     <= in_pt;
            r_rd_idx    <= '0;
            r_have_best <= 1'b0;
            r_found     <= 1'b0;
            r_near      <= '0;
            r_status    <= psnn_pkg::ST_OK;
            if ((i_in_data.opcode == psnn_pkg::OP_INSERT) && table_full) begin
                r_status <= psnn_pkg::ST_FULL;
            end
            if ((i_in_data.opcode == psnn_pkg::OP_NEAREST) && (r_count == '0)) begin
                r_status <= psnn_pkg::ST_EMPTY;
            end
        end
        if (r_state == S_SCAN) begin
            if (better) begin
                r_have_best <= 1'b1;
                r_best      <= sum;
                r_near      <= r_b_pt;
            end
            if ((r_op != psnn_pkg::OP_NEAREST) && match) begin
                r_found <= 1'b1;
            end else if ((r_op != psnn_pkg::OP_NEAREST) && scan_done) begin
                r_status <= psnn_pkg::ST_NOT_FOUND;
            end
        end
        if ((r_state == S_FIN) && (!r_out_valid || i_out_ready)) begin
            r_out.status      <= r_status;
            r_out.found       <= r_found;
            r_out.near_x      <= r_near.x;
            r_out.near_y      <= r_near.y;
            r_out.near_z      <= r_near.z;
            r_out.point_count <= psnn_pkg::CNT_W'(r_count);
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_a_valid   <= 1'b0;
            r_b_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_a_valid <= issue;
            r_b_valid <= r_a_valid && (r_state == S_SCAN) && (r_op == psnn_pkg::OP_NEAREST);
            if (in_acc && (i_in_data.opcode == psnn_pkg::OP_INSERT) && !table_full) begin
                r_count <= r_count + CW'(1);
            end else if ((r_state == S_SHIFT) && shift_done) begin
                r_count <= r_count - CW'(1);
            end
            if ((r_state == S_FIN) && (!r_out_valid || i_out_ready)) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("point count above capacity");

    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_in_data.opcode == psnn_pkg::OP_INSERT) && !table_full)
        |=> (r_count == $past(r_count) + CW'(1)))
        else $error("insert did not grow the store");

    a_delete_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_SHIFT) && shift_done) |=> (r_count == $past(r_count) - CW'(1)))
        else $error("delete did not shrink the store");

    a_write_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        we |-> (in_acc || (r_state == S_SHIFT)))
        else $error("table written outside insert or delete");

    a_result_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_FIN))
        else $error("result word loaded outside finish state");

endmodule

`default_nettype wire
